@@ hw/rtl/iamd_pkg.sv @@
// ----------------------------------------------------------------------------
// iamd_pkg
// Shared types and constants of the input action mapper with deadzone.
// ----------------------------------------------------------------------------
package iamd_pkg;

	localparam int LVL_W           = 16;  // level and deadzone width, Q0.16
	localparam int IDX_PORT_W      = 4;   // width of the input index field
	localparam int MASK_W          = 16;  // width of a binding mask
	localparam int MAX_ACT         = 4;   // action slots on the result ports
	localparam int ACT_W           = 2;   // action counter width
	localparam int CFG_IDX_W       = 3;   // register index width
	localparam int NUM_INPUTS_DEF  = 16;
	localparam int NUM_ACTIONS_DEF = 4;
	localparam int DIV_STEPS       = LVL_W;
	localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

	localparam logic [LVL_W-1:0] FULL_LEVEL = {LVL_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MASK_A0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DZ_A0   = 3'd4;

	// edge codes
	typedef enum logic [1:0] {
		EDGE_NONE = 2'd0,
		EDGE_ON   = 2'd1,
		EDGE_OFF  = 2'd2
	} edge_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INPUT,
		ST_ACT,
		ST_SCAN,
		ST_DZ,
		ST_DIV,
		ST_EDGE,
		ST_DONE
	} iamd_state_t;

	function automatic edge_t edge_code(input logic [LVL_W-1:0] prev,
			input logic [LVL_W-1:0] now);
		edge_t e;
		e = EDGE_NONE;
		if (now != '0 && prev == '0) begin
			e = EDGE_ON;
		end else if (now == '0 && prev != '0) begin
			e = EDGE_OFF;
		end
		return e;
	endfunction

endpackage

@@ hw/rtl/input_action_mapper_deadzone.sv @@
// ----------------------------------------------------------------------------
// input_action_mapper_deadzone
// Maps physical input levels onto up to four actions, each with the maximum
// of its bound inputs rescaled through a per-action deadzone.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// input     in         start & !busy        input_index, new_level
// result    out        done (one cycle)     input_edge, edge_a0..3, level_a0..3
// config    in         cfg_we               cfg_index, cfg_wdata
//
// The result is taken after the input step, an action step for each action,
// and for each bound action a rescan of the bound inputs when its level does
// not rise past the held raw level, the deadzone step, the restoring divider
// of the deadzone rescale when it runs, and the edge step; the next
// transaction can be accepted in the cycle after the result. The shared
// divider and the single read port of the input level registers set this
// timing.
// Reset clears all levels, masks and deadzones at once.
// The result is shown for exactly one cycle with done; the receiver cannot stall.
//
module input_action_mapper_deadzone #(
	parameter int NUM_INPUTS  = iamd_pkg::NUM_INPUTS_DEF,
	parameter int NUM_ACTIONS = iamd_pkg::NUM_ACTIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [iamd_pkg::IDX_PORT_W-1:0]   input_index,
	input  logic [iamd_pkg::LVL_W-1:0]        new_level,
	output logic                              done,
	output logic [1:0]                        input_edge,
	output logic [1:0]                        edge_a0,
	output logic [1:0]                        edge_a1,
	output logic [1:0]                        edge_a2,
	output logic [1:0]                        edge_a3,
	output logic [iamd_pkg::LVL_W-1:0]        level_a0,
	output logic [iamd_pkg::LVL_W-1:0]        level_a1,
	output logic [iamd_pkg::LVL_W-1:0]        level_a2,
	output logic [iamd_pkg::LVL_W-1:0]        level_a3,
	input  logic                              cfg_we,
	input  logic [iamd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [iamd_pkg::LVL_W-1:0]        cfg_wdata
);
	import iamd_pkg::*;

	// only the first sixteen inputs can be addressed or bound
	localparam int N_IN  = (NUM_INPUTS < MASK_W) ? NUM_INPUTS : MASK_W;
	localparam int IDX_W = (N_IN > 1) ? $clog2(N_IN) : 1;

	iamd_state_t state_q, state_d;

	logic [MASK_W-1:0]    mask_q    [MAX_ACT];
	logic [LVL_W-1:0]     dz_q      [MAX_ACT];
	logic [LVL_W-1:0]     in_lvl_q  [N_IN];
	logic [LVL_W-1:0]     raw_q     [MAX_ACT];
	logic [LVL_W-1:0]     out_lvl_q [MAX_ACT];
	edge_t                act_edge_q[MAX_ACT];
	edge_t                in_edge_q;

	logic [IDX_PORT_W-1:0] idx_q;
	logic [LVL_W-1:0]      lvl_q;
	logic [ACT_W-1:0]      act_q;
	logic [IDX_W-1:0]      scan_q;
	logic [LVL_W-1:0]      raw_cur_q;

	// divider payload
	logic [LVL_W-1:0]     rem_q;
	logic [LVL_W-1:0]     num_lo_q;
	logic [LVL_W-1:0]     div_q;
	logic [LVL_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic                 idx_ok;
	logic [IDX_W-1:0]     rd_addr;
	logic [LVL_W-1:0]     rd_lvl;
	logic                 act_bound;
	logic                 act_last;
	logic                 scan_last;
	logic                 dz_zero;
	logic [LVL_W-1:0]     dz_diff;
	logic [2*LVL_W-1:0]   dz_num;
	logic [LVL_W:0]       div_shift;
	logic [LVL_W:0]       div_trial;
	logic                 div_take;

	assign idx_ok    = ({1'b0, idx_q} < (IDX_PORT_W+1)'(N_IN));
	assign rd_addr   = (state_q == ST_INPUT) ? idx_q[IDX_W-1:0] : scan_q;
	assign rd_lvl    = in_lvl_q[rd_addr];
	assign act_bound = mask_q[act_q][idx_q];
	assign act_last  = (act_q == ACT_W'(NUM_ACTIONS-1));
	assign scan_last = (scan_q == IDX_W'(N_IN-1));
	assign dz_zero   = (dz_q[act_q] == FULL_LEVEL) || (raw_cur_q < dz_q[act_q]);
	assign dz_diff   = raw_cur_q - dz_q[act_q];
	// (raw - dz) * FULL as a shift and subtract
	assign dz_num    = {dz_diff, {LVL_W{1'b0}}} - {{LVL_W{1'b0}}, dz_diff};
	assign div_shift = {rem_q, num_lo_q[LVL_W-1]};
	assign div_trial = div_shift - {1'b0, div_q};
	assign div_take  = !div_trial[LVL_W];

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_INPUT;
				end
			end
			ST_INPUT: begin
				state_d = idx_ok ? ST_ACT : ST_DONE;
			end
			ST_ACT: begin
				if (!act_bound) begin
					state_d = act_last ? ST_DONE : ST_ACT;
				end else if (lvl_q > raw_q[act_q]) begin
					state_d = ST_DZ;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DZ;
				end
			end
			ST_DZ: begin
				state_d = dz_zero ? ST_EDGE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS-1)) begin
					state_d = ST_EDGE;
				end
			end
			ST_EDGE: begin
				state_d = act_last ? ST_DONE : ST_ACT;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// architectural state and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < MAX_ACT; a++) begin
				mask_q[a]     <= '0;
				dz_q[a]       <= '0;
				raw_q[a]      <= '0;
				out_lvl_q[a]  <= '0;
				act_edge_q[a] <= EDGE_NONE;
			end
			for (int i = 0; i < N_IN; i++) begin
				in_lvl_q[i] <= '0;
			end
			in_edge_q <= EDGE_NONE;
			act_q     <= '0;
			scan_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index < REG_DZ_A0) begin
					mask_q[cfg_index[ACT_W-1:0]] <= cfg_wdata;
				end else begin
					dz_q[cfg_index[ACT_W-1:0]] <= cfg_wdata;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						in_edge_q <= EDGE_NONE;
						act_q     <= '0;
						for (int a = 0; a < MAX_ACT; a++) begin
							act_edge_q[a] <= EDGE_NONE;
						end
					end
				end
				ST_INPUT: begin
					if (idx_ok) begin
						in_edge_q         <= edge_code(rd_lvl, lvl_q);
						in_lvl_q[rd_addr] <= lvl_q;
					end
				end
				ST_ACT: begin
					scan_q <= '0;
					if (!act_bound && !act_last) begin
						act_q <= act_q + 1'b1;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
				end
				ST_DZ: begin
					raw_q[act_q] <= raw_cur_q;
				end
				ST_EDGE: begin
					act_edge_q[act_q] <= edge_code(out_lvl_q[act_q], quo_q);
					out_lvl_q[act_q]  <= quo_q;
					if (!act_last) begin
						act_q <= act_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers of the item, the running maximum and the divider
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					idx_q <= input_index;
					lvl_q <= new_level;
				end
			end
			ST_ACT: begin
				raw_cur_q <= (lvl_q > raw_q[act_q]) ? lvl_q : '0;
			end
			ST_SCAN: begin
				if (mask_q[act_q][scan_q] && rd_lvl > raw_cur_q) begin
					raw_cur_q <= rd_lvl;
				end
			end
			ST_DZ: begin
				// quotient fits the level width since raw - dz <= FULL - dz
				rem_q    <= dz_num[2*LVL_W-1:LVL_W];
				num_lo_q <= dz_num[LVL_W-1:0];
				div_q    <= ~dz_q[act_q];
				quo_q    <= '0;
				cnt_q    <= '0;
			end
			ST_DIV: begin
				rem_q    <= div_take ? div_trial[LVL_W-1:0] : div_shift[LVL_W-1:0];
				num_lo_q <= {num_lo_q[LVL_W-2:0], 1'b0};
				quo_q    <= {quo_q[LVL_W-2:0], div_take};
				cnt_q    <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign input_edge = in_edge_q;
	assign edge_a0    = (0 < NUM_ACTIONS) ? act_edge_q[0] : EDGE_NONE;
	assign edge_a1    = (1 < NUM_ACTIONS) ? act_edge_q[1] : EDGE_NONE;
	assign edge_a2    = (2 < NUM_ACTIONS) ? act_edge_q[2] : EDGE_NONE;
	assign edge_a3    = (3 < NUM_ACTIONS) ? act_edge_q[3] : EDGE_NONE;
	assign level_a0   = (0 < NUM_ACTIONS) ? out_lvl_q[0] : '0;
	assign level_a1   = (1 < NUM_ACTIONS) ? out_lvl_q[1] : '0;
	assign level_a2   = (2 < NUM_ACTIONS) ? out_lvl_q[2] : '0;
	assign level_a3   = (3 < NUM_ACTIONS) ? out_lvl_q[3] : '0;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not make the block busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block stayed busy after the result");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && edge_a0 == EDGE_OFF |-> level_a0 == '0)
		else $error("action 0 deactivated with a nonzero level");

	a_on_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && edge_a0 == EDGE_ON |-> level_a0 != '0)
		else $error("action 0 activated with a zero level");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> mask_q[act_q][idx_q])
		else $error("rescan of an action not bound to the input");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for input_action_mapper_deadzone: drives input level
// changes and binding/deadzone settings, tracks the expected input and action
// edges and deadzoned levels, and compares every reported transaction.
// ----------------------------------------------------------------------------
module tb;

	import iamd_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int DRAIN_CYCLES    = 150;

	typedef struct packed {
		logic [1:0]                      in_edge;
		logic [MAX_ACT-1:0][1:0]         act_edge;
		logic [MAX_ACT-1:0][LVL_W-1:0]   level;
	} action_report_t;

	// tracks stored input levels and per-action levels, queues the reports due
	class action_level_tracker;
		logic [MASK_W-1:0] bind_mask [MAX_ACT];
		logic [LVL_W-1:0]  dz_level [MAX_ACT];
		logic [LVL_W-1:0]  input_level [NUM_INPUTS_DEF];
		logic [LVL_W-1:0]  raw_level [MAX_ACT];
		logic [LVL_W-1:0]  out_level [MAX_ACT];
		action_report_t    pending_reports [$];
		int                errors;

		function new();
			int k;
			for (k = 0; k < MAX_ACT; k++) begin
				bind_mask[k] = '0;
				dz_level[k]  = '0;
				raw_level[k] = '0;
				out_level[k] = '0;
			end
			for (k = 0; k < NUM_INPUTS_DEF; k++) begin
				input_level[k] = '0;
			end
			errors = 0;
		endfunction

		function edge_t level_edge(logic [LVL_W-1:0] prev, logic [LVL_W-1:0] now);
			if (prev == '0 && now != '0) begin
				return EDGE_ON;
			end
			if (prev != '0 && now == '0) begin
				return EDGE_OFF;
			end
			return EDGE_NONE;
		endfunction

		// (raw - dz) / (1 - dz) in Q0.16, zero inside the deadzone
		function logic [LVL_W-1:0] rescale(logic [LVL_W-1:0] raw, logic [LVL_W-1:0] dz);
			logic [2*LVL_W-1:0] num;
			logic [2*LVL_W-1:0] quot;
			if (dz == FULL_LEVEL || raw < dz) begin
				return '0;
			end
			num  = ({{LVL_W{1'b0}}, raw} - dz) * FULL_LEVEL;
			quot = num / ({{LVL_W{1'b0}}, FULL_LEVEL} - dz);
			return quot[LVL_W-1:0];
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] ri, logic [LVL_W-1:0] d);
			if (ri < REG_DZ_A0) begin
				bind_mask[ri - REG_MASK_A0] = d;
			end else begin
				dz_level[ri - REG_DZ_A0] = d;
			end
		endfunction

		function void note_input_change(logic [IDX_PORT_W-1:0] idx, logic [LVL_W-1:0] lvl);
			action_report_t r;
			logic [LVL_W-1:0] raw;
			logic [LVL_W-1:0] lvl_out;
			int a;
			int i;
			r = '0;
			r.in_edge = level_edge(input_level[idx], lvl);
			input_level[idx] = lvl;
			for (a = 0; a < MAX_ACT; a++) begin
				if (bind_mask[a][idx]) begin
					if (lvl > raw_level[a]) begin
						raw = lvl;
					end else begin
						// level did not rise past the held raw level: rescan bound inputs
						raw = '0;
						for (i = 0; i < NUM_INPUTS_DEF; i++) begin
							if (bind_mask[a][i] && input_level[i] > raw) begin
								raw = input_level[i];
							end
						end
					end
					raw_level[a] = raw;
					lvl_out = rescale(raw, dz_level[a]);
					r.act_edge[a] = level_edge(out_level[a], lvl_out);
					out_level[a] = lvl_out;
				end
				r.level[a] = out_level[a];
			end
			pending_reports.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
			if (exp_v != got_v) begin
				errors++;
				$display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, got_v);
			end
		endfunction

		function void check_report(action_report_t got);
			action_report_t exp_r;
			int a;
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction: expected none, actual %h", $time, got);
				return;
			end
			exp_r = pending_reports.pop_front();
			compare_field("input_edge", exp_r.in_edge, got.in_edge);
			for (a = 0; a < MAX_ACT; a++) begin
				compare_field($sformatf("edge_a%0d", a), exp_r.act_edge[a], got.act_edge[a]);
				compare_field($sformatf("level_a%0d", a), exp_r.level[a], got.level[a]);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [IDX_PORT_W-1:0]  input_index;
	logic [LVL_W-1:0]       new_level;
	logic                   done;
	logic [1:0]             input_edge;
	logic [1:0]             edge_a0;
	logic [1:0]             edge_a1;
	logic [1:0]             edge_a2;
	logic [1:0]             edge_a3;
	logic [LVL_W-1:0]       level_a0;
	logic [LVL_W-1:0]       level_a1;
	logic [LVL_W-1:0]       level_a2;
	logic [LVL_W-1:0]       level_a3;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [LVL_W-1:0]       cfg_wdata;

	action_level_tracker tracker = new();
	int                  quiet_cycles = 0;

	input_action_mapper_deadzone i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.input_index (input_index),
		.new_level   (new_level),
		.done        (done),
		.input_edge  (input_edge),
		.edge_a0     (edge_a0),
		.edge_a1     (edge_a1),
		.edge_a2     (edge_a2),
		.edge_a3     (edge_a3),
		.level_a0    (level_a0),
		.level_a1    (level_a1),
		.level_a2    (level_a2),
		.level_a3    (level_a3),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result check comes first: a report at an accept edge belongs to the previous transaction
	always @(posedge clk) begin
		action_report_t got;
		if (arst_n) begin
			if (done) begin
				got.in_edge     = input_edge;
				got.act_edge[0] = edge_a0;
				got.act_edge[1] = edge_a1;
				got.act_edge[2] = edge_a2;
				got.act_edge[3] = edge_a3;
				got.level[0]    = level_a0;
				got.level[1]    = level_a1;
				got.level[2]    = level_a2;
				got.level[3]    = level_a3;
				tracker.check_report(got);
			end
			if (start && !busy) begin
				tracker.note_input_change(input_index, new_level);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("FAIL input_action_mapper_deadzone");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [LVL_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= ri;
		cfg_wdata <= d;
		tracker.write_reg(ri, d);
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [MAX_ACT-1:0][MASK_W-1:0] masks,
			input logic [MAX_ACT-1:0][LVL_W-1:0] dzs);
		int a;
		for (a = 0; a < MAX_ACT; a++) begin
			write_reg(CFG_IDX_W'(REG_MASK_A0 + a), masks[a]);
		end
		for (a = 0; a < MAX_ACT; a++) begin
			write_reg(CFG_IDX_W'(REG_DZ_A0 + a), dzs[a]);
		end
		cfg_we <= 1'b0;
	endtask

	// wait until the last transaction has reported and the block is idle
	task automatic wait_idle();
		do @(posedge clk); while (tracker.pending_reports.size() != 0 || busy);
	endtask

	// random idle cycles with junk on the payload, then one transaction
	task automatic send_change(input logic [IDX_PORT_W-1:0] idx, input logic [LVL_W-1:0] lvl,
			input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start       <= 1'b0;
			input_index <= IDX_PORT_W'($urandom);
			new_level   <= LVL_W'($urandom);
			@(posedge clk);
		end
		start       <= 1'b1;
		input_index <= idx;
		new_level   <= lvl;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [LVL_W-1:0] pick_level();
		case ($urandom_range(9))
			0, 1, 2: return '0;
			3:       return FULL_LEVEL;
			4:       return LVL_W'($urandom_range(255));
			5:       return LVL_W'(FULL_LEVEL - $urandom_range(255));
			default: return LVL_W'($urandom);
		endcase
	endfunction

	function automatic logic [LVL_W-1:0] pick_mask();
		case ($urandom_range(5))
			0:       return '0;
			1:       return '1;
			2:       return 16'h1 << $urandom_range(MASK_W - 1);
			3:       return LVL_W'($urandom & $urandom);
			default: return LVL_W'($urandom);
		endcase
	endfunction

	function automatic logic [LVL_W-1:0] pick_deadzone();
		case ($urandom_range(5))
			0:       return '0;
			1:       return FULL_LEVEL;
			2:       return FULL_LEVEL - 1'b1;
			3:       return 16'd1;
			4:       return LVL_W'($urandom_range(8191));
			default: return LVL_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [MAX_ACT-1:0][MASK_W-1:0] masks;
		logic [MAX_ACT-1:0][LVL_W-1:0]  dzs;
		logic [MASK_W-1:0]              bound_any;
		logic [IDX_PORT_W-1:0]          idx;
		int                             idle_mode [5];
		int                             phase;
		int                             n;
		int                             a;

		idle_mode = '{0, 56, 15, 0, 56};
		arst_n      <= 1'b0;
		start       <= 1'b0;
		input_index <= '0;
		new_level   <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_wdata   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full mask, single input, shared inputs, unbound action;
		// deadzones zero, full, half and one lsb
		masks = '{16'h0000, 16'h80F0, 16'h0001, 16'hFFFF};
		dzs   = '{16'h0001, 16'h8000, FULL_LEVEL, 16'h0000};
		load_settings(masks, dzs);
		send_change(4'd0, FULL_LEVEL, 0);
		send_change(4'd0, 16'h0000, 0);
		send_change(4'd15, 16'h0001, 0);
		send_change(4'd15, 16'h8000, 0);
		send_change(4'd4, 16'h9000, 0);
		send_change(4'd15, 16'h4000, 0);   // below held raw level: rescan keeps input 4
		send_change(4'd4, 16'h0000, 0);    // falls into the deadzone
		send_change(4'd15, FULL_LEVEL, 0);
		send_change(4'd15, 16'hFFFE, 0);
		send_change(4'd7, FULL_LEVEL, 0);
		send_change(4'd5, 16'h7FFF, 0);
		send_change(4'd0, 16'h0001, 0);
		send_change(4'd3, 16'h0000, 0);
		send_change(4'd7, 16'h0000, 0);
		send_change(4'd15, 16'h0000, 0);
		send_change(4'd5, 16'h0000, 0);
		start <= 1'b0;
		wait_idle();

		// mask changes only act on the next change of a bound input
		masks = '{16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};
		dzs   = '{FULL_LEVEL, 16'h0000, 16'h0001, FULL_LEVEL - 1'b1};
		load_settings(masks, dzs);
		send_change(4'd1, 16'h1234, 0);
		send_change(4'd2, FULL_LEVEL, 0);
		send_change(4'd2, 16'h0000, 0);
		send_change(4'd1, 16'h0000, 0);
		start <= 1'b0;

		for (phase = 0; phase < 5; phase++) begin
			wait_idle();
			for (a = 0; a < MAX_ACT; a++) begin
				masks[a] = pick_mask();
				dzs[a]   = pick_deadzone();
			end
			load_settings(masks, dzs);
			bound_any = masks[0] | masks[1] | masks[2] | masks[3];
			for (n = 0; n < 96; n++) begin
				// mostly bound inputs so that action levels really move
				if (bound_any != '0 && $urandom_range(3) != 0) begin
					do idx = IDX_PORT_W'($urandom); while (!bound_any[idx]);
				end else begin
					idx = IDX_PORT_W'($urandom);
				end
				send_change(idx, pick_level(), idle_mode[phase]);
			end
			start <= 1'b0;
		end

		while (tracker.pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("PASS input_action_mapper_deadzone");
		end else begin
			$display("FAIL input_action_mapper_deadzone");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/iamd_pkg.sv
hw/rtl/input_action_mapper_deadzone.sv
bench/tb.sv
